### rtl/core/gsp_pkg.sv
// Shared types and character codes for the geometry string parser.
// Used by every module of the parser; depends on nothing.
`default_nettype none

package gsp_pkg;

    localparam int unsigned CHAR_BITS = 8;
    localparam int unsigned MASK_BITS = 6;
    localparam int unsigned OFFSET_BITS = 17;
    localparam int unsigned SIZE_BITS = 16;

    localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_BITS-1:0] CHAR_EQ    = 8'h3D;
    localparam logic [CHAR_BITS-1:0] CHAR_LX    = 8'h78;
    localparam logic [CHAR_BITS-1:0] CHAR_UX    = 8'h58;
    localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;

    localparam int unsigned MB_X    = 0;
    localparam int unsigned MB_Y    = 1;
    localparam int unsigned MB_W    = 2;
    localparam int unsigned MB_H    = 3;
    localparam int unsigned MB_XNEG = 4;
    localparam int unsigned MB_YNEG = 5;

    typedef enum logic [3:0] {
        PH_START  = 4'd0,
        PH_WSTART = 4'd1,
        PH_WDIG   = 4'd2,
        PH_HSTART = 4'd3,
        PH_HDIG   = 4'd4,
        PH_XSTART = 4'd5,
        PH_XDIG   = 4'd6,
        PH_YSTART = 4'd7,
        PH_YDIG   = 4'd8,
        PH_ERR    = 4'd9
    } gsp_phase_t;

    typedef struct packed {
        logic                 valid;
        logic [CHAR_BITS-1:0] char_code;
    } gsp_item_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0]   height_value;
        logic [SIZE_BITS-1:0]   width_value;
        logic [OFFSET_BITS-1:0] y_offset;
        logic [OFFSET_BITS-1:0] x_offset;
        logic [MASK_BITS-1:0]   value_mask;
    } gsp_result_t;

endpackage

`default_nettype wire

### rtl/core/gsp_input_stage.sv
// Input register of the geometry string parser: holds one character word.
// Depends on gsp_pkg.
`default_nettype none

module gsp_input_stage
    import gsp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [CHAR_BITS-1:0] s_tdata,
    input  wire logic                 take,
    output gsp_item_t                 item
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [CHAR_BITS-1:0] char_reg;

    assign s_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            char_reg <= s_tdata;
        end
    end

    assign item = {valid_reg, char_reg};

endmodule

`default_nettype wire

### rtl/core/gsp_parse_engine.sv
// Parser state and per-character update logic for geometry strings.
// Depends on gsp_pkg; the result is combinational and is registered outside.
`default_nettype none

module gsp_parse_engine
    import gsp_pkg::*;
#(
    parameter int unsigned MAGNITUDE_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [CHAR_BITS-1:0] char_code,
    output gsp_result_t               result
);

    localparam int unsigned SUM_BITS = MAGNITUDE_BITS + 4;

    gsp_phase_t                phase_reg,  phase_next;
    logic                      sign_reg,   sign_next;
    logic [MAGNITUDE_BITS-1:0] acc_reg,    acc_next;
    logic [SIZE_BITS-1:0]      width_reg,  width_next;
    logic [SIZE_BITS-1:0]      height_reg, height_next;
    logic [OFFSET_BITS-1:0]    x_reg,      x_next;
    logic [OFFSET_BITS-1:0]    y_reg,      y_next;
    logic [MASK_BITS-1:0]      mask_reg,   mask_next;

    logic                      is_digit;
    logic                      is_sign;
    logic                      is_minus;
    logic [3:0]                digit;
    logic [SUM_BITS-1:0]       acc_sum;
    logic [MAGNITUDE_BITS-1:0] acc_digit;
    logic [MAGNITUDE_BITS+16:0] acc_wide;
    logic [OFFSET_BITS-1:0]    acc17;
    logic                      x_neg;
    logic                      y_neg;
    logic                      field_done;
    logic [SIZE_BITS-1:0]      width_c;
    logic [SIZE_BITS-1:0]      height_c;
    logic [OFFSET_BITS-1:0]    x_c;
    logic [OFFSET_BITS-1:0]    y_c;
    logic [MASK_BITS-1:0]      mask_c;
    logic [MASK_BITS-1:0]      neg_bit_x;
    logic [MASK_BITS-1:0]      neg_bit_y;

    assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign is_minus = (char_code == CHAR_MINUS);
    assign is_sign  = (char_code == CHAR_PLUS) || is_minus;
    assign digit    = 4'(char_code - CHAR_ZERO);

    // The accumulator times ten plus the new digit, clamped at the largest magnitude.
    assign acc_sum   = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                     + SUM_BITS'(digit);
    assign acc_digit = (|acc_sum[SUM_BITS-1:MAGNITUDE_BITS]) ? '1
                                                             : acc_sum[MAGNITUDE_BITS-1:0];

    assign acc_wide = {17'd0, acc_reg};
    assign acc17    = acc_wide[OFFSET_BITS-1:0];
    assign x_neg    = sign_reg ^ mask_reg[MB_XNEG];
    assign y_neg    = sign_reg ^ mask_reg[MB_YNEG];

    assign neg_bit_x = is_minus ? MASK_BITS'(1 << MB_XNEG) : '0;
    assign neg_bit_y = is_minus ? MASK_BITS'(1 << MB_YNEG) : '0;

    // Held values and mask with the field under way folded in.
    always_comb
    begin
        width_c  = width_reg;
        height_c = height_reg;
        x_c      = x_reg;
        y_c      = y_reg;
        mask_c   = mask_reg;
        case (phase_reg)
            PH_WDIG:
            begin
                width_c        = acc17[SIZE_BITS-1:0];
                mask_c[MB_W]   = 1'b1;
            end
            PH_HDIG:
            begin
                height_c       = sign_reg ? (SIZE_BITS'(0) - acc17[SIZE_BITS-1:0])
                                          : acc17[SIZE_BITS-1:0];
                mask_c[MB_H]   = 1'b1;
            end
            PH_XDIG:
            begin
                x_c            = x_neg ? (OFFSET_BITS'(0) - acc17) : acc17;
                mask_c[MB_X]   = 1'b1;
            end
            PH_YDIG:
            begin
                y_c            = y_neg ? (OFFSET_BITS'(0) - acc17) : acc17;
                mask_c[MB_Y]   = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign field_done = (phase_reg == PH_WDIG) || (phase_reg == PH_HDIG)
                     || (phase_reg == PH_XDIG) || (phase_reg == PH_YDIG);

    always_comb
    begin
        if (field_done)
        begin
            result.value_mask   = mask_c;
            result.x_offset     = x_c;
            result.y_offset     = y_c;
            result.width_value  = width_c;
            result.height_value = height_c;
        end
        else
        begin
            result = '0;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        sign_next   = sign_reg;
        acc_next    = acc_reg;
        width_next  = width_reg;
        height_next = height_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        mask_next   = mask_reg;

        if (char_code == CHAR_NUL)
        begin
            phase_next  = PH_START;
            sign_next   = 1'b0;
            acc_next    = '0;
            width_next  = '0;
            height_next = '0;
            x_next      = '0;
            y_next      = '0;
            mask_next   = '0;
        end
        else
        begin
            case (phase_reg)
                PH_START, PH_WSTART:
                begin
                    if ((phase_reg == PH_START) && (char_code == CHAR_EQ))
                    begin
                        phase_next = PH_WSTART;
                    end
                    else if (is_sign)
                    begin
                        mask_next  = mask_reg | neg_bit_x;
                        phase_next = PH_XSTART;
                        sign_next  = 1'b0;
                        acc_next   = '0;
                    end
                    else if (char_code == CHAR_LX)
                    begin
                        phase_next = PH_HSTART;
                        sign_next  = 1'b0;
                        acc_next   = '0;
                    end
                    else if (is_digit)
                    begin
                        acc_next   = acc_digit;
                        phase_next = PH_WDIG;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                    end
                end
                PH_WDIG:
                begin
                    if (is_digit)
                    begin
                        acc_next = acc_digit;
                    end
                    else if ((char_code == CHAR_LX) || (char_code == CHAR_UX))
                    begin
                        width_next = width_c;
                        mask_next  = mask_c;
                        phase_next = PH_HSTART;
                        sign_next  = 1'b0;
                        acc_next   = '0;
                    end
                    else if (is_sign)
                    begin
                        width_next = width_c;
                        mask_next  = mask_c | neg_bit_x;
                        phase_next = PH_XSTART;
                        sign_next  = 1'b0;
                        acc_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                    end
                end
                PH_HSTART, PH_XSTART, PH_YSTART:
                begin
                    if (is_sign || is_digit)
                    begin
                        if (is_sign)
                        begin
                            sign_next = is_minus;
                        end
                        else
                        begin
                            acc_next = acc_digit;
                        end
                        case (phase_reg)
                            PH_HSTART: phase_next = PH_HDIG;
                            PH_XSTART: phase_next = PH_XDIG;
                            default:   phase_next = PH_YDIG;
                        endcase
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                    end
                end
                PH_HDIG:
                begin
                    if (is_digit)
                    begin
                        acc_next = acc_digit;
                    end
                    else if (is_sign)
                    begin
                        height_next = height_c;
                        mask_next   = mask_c | neg_bit_x;
                        phase_next  = PH_XSTART;
                        sign_next   = 1'b0;
                        acc_next    = '0;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                    end
                end
                PH_XDIG:
                begin
                    if (is_digit)
                    begin
                        acc_next = acc_digit;
                    end
                    else if (is_sign)
                    begin
                        x_next     = x_c;
                        mask_next  = mask_c | neg_bit_y;
                        phase_next = PH_YSTART;
                        sign_next  = 1'b0;
                        acc_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                    end
                end
                PH_YDIG:
                begin
                    if (is_digit)
                    begin
                        acc_next = acc_digit;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                    end
                end
                default:
                begin
                    phase_next = PH_ERR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            sign_reg   <= 1'b0;
            acc_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            mask_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            sign_reg   <= sign_next;
            acc_reg    <= acc_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            mask_reg   <= mask_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/gsp_output_stage.sv
// Result register of the geometry string parser, drives the master side.
// Depends on gsp_pkg.
`default_nettype none

module gsp_output_stage
    import gsp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  gsp_result_t      result,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output gsp_result_t      data
);

    logic        valid_reg;
    logic        valid_next;
    gsp_result_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign data     = data_reg;

endmodule

`default_nettype wire

### rtl/core/geometry_string_parser_core.sv
// Geometry string parser: one character word per cycle, one result word per string.
// A terminating zero is held until the result register is free, then loads its result word.
// Throughput: one character per cycle; only the result register can hold the input back.
// Reset: asynchronous, active low; clears the parse state and both stage valids.
// Depends on gsp_pkg, gsp_input_stage, gsp_parse_engine and gsp_output_stage.
`default_nettype none

module geometry_string_parser_core
    import gsp_pkg::*;
#(
    parameter int unsigned MAGNITUDE_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // char_code[7:0]
    input  wire logic [7:0]  s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // value_mask[5:0], x_offset[22:6], y_offset[39:23], width_value[55:40],
    // height_value[71:56]
    output logic [71:0]      m_tdata
);

    gsp_item_t   item;
    gsp_result_t result;
    gsp_result_t out_data;
    logic        out_free;
    logic        take;
    logic        load;

    assign out_free = !m_tvalid || m_tready;
    assign take     = item.valid && ((item.char_code != CHAR_NUL) || out_free);
    assign load     = take && (item.char_code == CHAR_NUL);

    gsp_input_stage u_input
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (take),
        .item     (item)
    );

    gsp_parse_engine #(
        .MAGNITUDE_BITS (MAGNITUDE_BITS)
    ) u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (take),
        .char_code (item.char_code),
        .result    (result)
    );

    gsp_output_stage u_output
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .data     (out_data)
    );

    assign m_tdata = 72'(out_data);

`ifndef SYNTHESIS
    a_neg_implies_present: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((!out_data.value_mask[MB_XNEG] || out_data.value_mask[MB_X])
                   && (!out_data.value_mask[MB_YNEG] || out_data.value_mask[MB_Y])))
        else $error("Sign bit set for an absent offset.");

    a_absent_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((out_data.value_mask[MB_X] || out_data.x_offset == '0)
                   && (out_data.value_mask[MB_Y] || out_data.y_offset == '0)
                   && (out_data.value_mask[MB_W] || out_data.width_value == '0)
                   && (out_data.value_mask[MB_H] || out_data.height_value == '0)))
        else $error("Absent field carries a nonzero value.");

    a_held_char_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && !take) |=> (item.valid && $stable(item.char_code)))
        else $error("Held character word was lost or overwritten.");
`endif

endmodule

`default_nettype wire

### sim/geometry_string_parser_core_test.sv
// Self-checking testbench for geometry_string_parser_core: feeds character words and checks
// each result word against a behavioral model of the geometry string syntax.
// Depends on gsp_pkg and geometry_string_parser_core.
`default_nettype none

module geometry_string_parser_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gsp_pkg::*;

    localparam int unsigned MAG_BITS = 16;
    localparam longint unsigned MAG_MAX = (64'd1 << MAG_BITS) - 64'd1;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned CHAR_TARGET = 2000;

    typedef logic [CHAR_BITS-1:0] char_q_t[$];

    class geometry_tracker;
        gsp_phase_t             phase;
        bit                     field_neg;
        logic [31:0]            magnitude;
        logic [SIZE_BITS-1:0]   held_width;
        logic [SIZE_BITS-1:0]   held_height;
        logic [OFFSET_BITS-1:0] held_x;
        logic [OFFSET_BITS-1:0] held_y;
        logic [MASK_BITS-1:0]   found;
        gsp_result_t            pending_geometry[$];
        int                     chars_taken;
        int                     strings_seen;
        int                     rejected;
        int                     fail_count;

        function new();
            clear_string();
        endfunction

        function void start_field();
            field_neg = 1'b0;
            magnitude = '0;
        endfunction

        function void clear_string();
            phase = PH_START;
            held_width = '0;
            held_height = '0;
            held_x = '0;
            held_y = '0;
            found = '0;
            start_field();
        endfunction

        function bit is_digit(logic [CHAR_BITS-1:0] c);
            return c >= CHAR_ZERO && c <= CHAR_NINE;
        endfunction

        function bit is_sign(logic [CHAR_BITS-1:0] c);
            return c == CHAR_PLUS || c == CHAR_MINUS;
        endfunction

        function void add_digit(logic [CHAR_BITS-1:0] c);
            longint unsigned v;
            v = 64'(magnitude) * 64'd10 + 64'(c - CHAR_ZERO);
            magnitude = (v > MAG_MAX) ? MAG_MAX[31:0] : v[31:0];
        endfunction

        function logic [31:0] signed_magnitude(bit neg);
            return neg ? (32'd0 - magnitude) : magnitude;
        endfunction

        function void begin_offset(logic [CHAR_BITS-1:0] c, gsp_phase_t next_phase,
                                   int unsigned neg_bit);
            if (c == CHAR_MINUS)
            begin
                found[neg_bit] = 1'b1;
            end
            phase = next_phase;
            start_field();
        endfunction

        function void commit_field();
            logic [31:0] v;
            case (phase)
                PH_WDIG:
                begin
                    held_width = magnitude[SIZE_BITS-1:0];
                    found[MB_W] = 1'b1;
                end
                PH_HDIG:
                begin
                    v = signed_magnitude(field_neg);
                    held_height = v[SIZE_BITS-1:0];
                    found[MB_H] = 1'b1;
                end
                PH_XDIG:
                begin
                    v = signed_magnitude(field_neg ^ found[MB_XNEG]);
                    held_x = v[OFFSET_BITS-1:0];
                    found[MB_X] = 1'b1;
                end
                PH_YDIG:
                begin
                    v = signed_magnitude(field_neg ^ found[MB_YNEG]);
                    held_y = v[OFFSET_BITS-1:0];
                    found[MB_Y] = 1'b1;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void width_start(logic [CHAR_BITS-1:0] c);
            if (is_sign(c))
            begin
                begin_offset(c, PH_XSTART, MB_XNEG);
            end
            else if (c == CHAR_LX)
            begin
                phase = PH_HSTART;
                start_field();
            end
            else if (is_digit(c))
            begin
                add_digit(c);
                phase = PH_WDIG;
            end
            else
            begin
                phase = PH_ERR;
            end
        endfunction

        function void field_start(logic [CHAR_BITS-1:0] c);
            gsp_phase_t next_phase;
            case (phase)
                PH_HSTART: next_phase = PH_HDIG;
                PH_XSTART: next_phase = PH_XDIG;
                default:   next_phase = PH_YDIG;
            endcase
            if (is_sign(c))
            begin
                field_neg = (c == CHAR_MINUS);
                phase = next_phase;
            end
            else if (is_digit(c))
            begin
                add_digit(c);
                phase = next_phase;
            end
            else
            begin
                phase = PH_ERR;
            end
        endfunction

        function void take_char(logic [CHAR_BITS-1:0] c);
            gsp_result_t want;
            bit          complete;
            chars_taken++;
            if (c == CHAR_NUL)
            begin
                complete = phase inside {PH_WDIG, PH_HDIG, PH_XDIG, PH_YDIG};
                want = '0;
                if (complete)
                begin
                    commit_field();
                    want.value_mask = found;
                    want.x_offset = held_x;
                    want.y_offset = held_y;
                    want.width_value = held_width;
                    want.height_value = held_height;
                end
                else
                begin
                    rejected++;
                end
                pending_geometry.push_back(want);
                strings_seen++;
                clear_string();
                return;
            end
            case (phase)
                PH_START:
                begin
                    if (c == CHAR_EQ)
                    begin
                        phase = PH_WSTART;
                    end
                    else
                    begin
                        width_start(c);
                    end
                end
                PH_WSTART:
                begin
                    width_start(c);
                end
                PH_WDIG:
                begin
                    if (is_digit(c))
                    begin
                        add_digit(c);
                    end
                    else if (c == CHAR_LX || c == CHAR_UX)
                    begin
                        commit_field();
                        phase = PH_HSTART;
                        start_field();
                    end
                    else if (is_sign(c))
                    begin
                        commit_field();
                        begin_offset(c, PH_XSTART, MB_XNEG);
                    end
                    else
                    begin
                        phase = PH_ERR;
                    end
                end
                PH_HSTART, PH_XSTART, PH_YSTART:
                begin
                    field_start(c);
                end
                PH_HDIG, PH_XDIG:
                begin
                    if (is_digit(c))
                    begin
                        add_digit(c);
                    end
                    else if (is_sign(c))
                    begin
                        if (phase == PH_HDIG)
                        begin
                            commit_field();
                            begin_offset(c, PH_XSTART, MB_XNEG);
                        end
                        else
                        begin
                            commit_field();
                            begin_offset(c, PH_YSTART, MB_YNEG);
                        end
                    end
                    else
                    begin
                        phase = PH_ERR;
                    end
                end
                PH_YDIG:
                begin
                    if (is_digit(c))
                    begin
                        add_digit(c);
                    end
                    else
                    begin
                        phase = PH_ERR;
                    end
                end
                default:
                begin
                    phase = PH_ERR;
                end
            endcase
        endfunction

        function void check_field(string name, logic [OFFSET_BITS-1:0] want,
                                  logic [OFFSET_BITS-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
                fail_count++;
            end
        endfunction

        function void check_geometry(logic [71:0] word);
            gsp_result_t got;
            gsp_result_t want;
            got = gsp_result_t'(word);
            if (pending_geometry.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, got 0x%0h", $time, word);
                fail_count++;
                return;
            end
            want = pending_geometry.pop_front();
            check_field("value_mask", OFFSET_BITS'(want.value_mask),
                        OFFSET_BITS'(got.value_mask));
            check_field("x_offset", want.x_offset, got.x_offset);
            check_field("y_offset", want.y_offset, got.y_offset);
            check_field("width_value", OFFSET_BITS'(want.width_value),
                        OFFSET_BITS'(got.width_value));
            check_field("height_value", OFFSET_BITS'(want.height_value),
                        OFFSET_BITS'(got.height_value));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    geometry_tracker tracker = new();
    bit              calm = 1'b0;
    int              ready_hold = 0;
    int              quiet_cycles = 0;
    int              chars_sent = 0;
    char_q_t         draft;
    string           directed_cases[] = '{"", "=", "X1", "99999x-3-+4--5", "x", "+5a"};

    geometry_string_parser_core #(
        .MAGNITUDE_BITS(MAG_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #6 clk = ~clk;

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
        begin
            return 0;
        end
        if (r < 60)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int digit_count();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 17)
        begin
            return $urandom_range(4, 5);
        end
        if (r < 19)
        begin
            return $urandom_range(6, 8);
        end
        return 0;
    endfunction

    function automatic logic [7:0] pick_sign();
        return ($urandom_range(0, 1) == 0) ? CHAR_PLUS : CHAR_MINUS;
    endfunction

    function automatic void add_digits(int count);
        bit nines;
        nines = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < count; i++)
        begin
            draft.push_back(nines ? CHAR_NINE : 8'(CHAR_ZERO + $urandom_range(0, 9)));
        end
    endfunction

    function automatic void add_offset();
        draft.push_back(pick_sign());
        if ($urandom_range(0, 3) == 0)
        begin
            draft.push_back(pick_sign());
        end
        add_digits(digit_count());
    endfunction

    // Mostly well-formed geometries with random content; the rest is noise or damaged.
    function automatic void make_geometry();
        draft.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(0, 6)) draft.push_back(8'($urandom_range(1, 255)));
            return;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            draft.push_back(CHAR_EQ);
        end
        if ($urandom_range(0, 3) != 0)
        begin
            add_digits(digit_count());
        end
        if ($urandom_range(0, 3) != 0)
        begin
            draft.push_back(($urandom_range(0, 3) == 0) ? CHAR_UX : CHAR_LX);
            if ($urandom_range(0, 3) == 0)
            begin
                draft.push_back(pick_sign());
            end
            add_digits(digit_count());
        end
        if ($urandom_range(0, 2) != 0)
        begin
            add_offset();
            if ($urandom_range(0, 2) != 0)
            begin
                add_offset();
            end
        end
        if ($urandom_range(0, 9) == 0)
        begin
            draft.push_back(pick_sign());
        end
        if ($urandom_range(0, 5) == 0)
        begin
            if (draft.size() != 0 && $urandom_range(0, 1) == 0)
            begin
                draft.delete($urandom_range(0, draft.size() - 1));
            end
            else
            begin
                draft.insert($urandom_range(0, draft.size()), 8'($urandom_range(1, 255)));
            end
        end
    endfunction

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = idle_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_string(input char_q_t body);
        foreach (body[i])
        begin
            send_char(body[i]);
        end
        send_char(CHAR_NUL);
    endtask

    always @(posedge clk)
    begin
        if ($urandom_range(0, 249) == 0)
        begin
            calm <= !calm;
        end
    end

    always @(posedge clk)
    begin
        if (ready_hold != 0)
        begin
            ready_hold--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            ready_hold = idle_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                tracker.take_char(s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                tracker.check_geometry(m_tdata);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("%0t: no word accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed_cases[n])
        begin
            draft.delete();
            for (int i = 0; i < directed_cases[n].len(); i++)
            begin
                draft.push_back(directed_cases[n][i]);
            end
            send_string(draft);
        end
        while (chars_sent < CHAR_TARGET)
        begin
            make_geometry();
            send_string(draft);
        end
        s_tvalid <= 1'b0;
        while (tracker.pending_geometry.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        $display("Sent %0d characters in %0d strings; %0d strings were rejected with mask 0.",
                 tracker.chars_taken, tracker.strings_seen, tracker.rejected);
        $display("Random stalls covered both the character and the result side.");
        if (tracker.fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
